[hw/rtl/mwpm_pkg.sv]
// Shared types and constants for the mecanum wheel PWM mixer.
// Holds the request and response payload structs, the product bundle and the CSR map.
// No dependencies.
package mwpm_pkg;

   localparam int SPEED_WIDTH    = 16;
   localparam int GAIN_WIDTH     = 18;
   localparam int MASK_WIDTH     = 4;
   localparam int WHEEL_COUNT    = 4;
   localparam int SPEED_FRAC     = 12;
   localparam int GAIN_FRAC      = 8;
   localparam int ROUND_SHIFT    = SPEED_FRAC + GAIN_FRAC;
   localparam int PROD_WIDTH     = SPEED_WIDTH + GAIN_WIDTH + 1;
   localparam int TERM_WIDTH     = PROD_WIDTH + 2;
   localparam int DUTY_WIDTH     = 11;
   localparam int OFF_WIDTH      = DUTY_WIDTH + 1;
   localparam int CSR_ADDR_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = GAIN_WIDTH;

   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_LINEAR_GAIN   = 2'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_ROTATION_GAIN = 2'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_INVERT_MASK   = 2'd2;

   localparam logic [GAIN_WIDTH-1:0] LINEAR_GAIN_RESET   = 18'd148475;
   localparam logic [GAIN_WIDTH-1:0] ROTATION_GAIN_RESET = 18'd74237;
   localparam logic [MASK_WIDTH-1:0] INVERT_MASK_RESET   = 4'd10;

   typedef struct packed {
      logic signed [SPEED_WIDTH-1:0] forward_speed;
      logic signed [SPEED_WIDTH-1:0] side_speed;
      logic signed [SPEED_WIDTH-1:0] turn_rate;
   } req_type;

   typedef struct packed {
      logic                  dir_one;
      logic                  dir_two;
      logic                  dir_three;
      logic                  dir_four;
      logic [DUTY_WIDTH-1:0] on_one;
      logic [DUTY_WIDTH-1:0] on_two;
      logic [DUTY_WIDTH-1:0] on_three;
      logic [DUTY_WIDTH-1:0] on_four;
      logic [OFF_WIDTH-1:0]  off_one;
      logic [OFF_WIDTH-1:0]  off_two;
      logic [OFF_WIDTH-1:0]  off_three;
      logic [OFF_WIDTH-1:0]  off_four;
   } rsp_type;

   typedef struct packed {
      logic signed [PROD_WIDTH-1:0] gx;
      logic signed [PROD_WIDTH-1:0] gy;
      logic signed [PROD_WIDTH-1:0] rz;
   } prod_type;

endpackage

[hw/rtl/mwpm_product.sv]
// Input register and gain multiplier stage of the mecanum wheel PWM mixer.
// Registers the command beat, then registers the three weighted speed products.
// Depends on mwpm_pkg.
module mwpm_product
   import mwpm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   input  logic [GAIN_WIDTH-1:0] linear_gain,
   input  logic [GAIN_WIDTH-1:0] rotation_gain,
   output logic                  prod_valid,
   input  logic                  prod_ready,
   output prod_type              prod_data
);

   logic     in_valid_ff, in_valid_in;
   req_type  in_data_ff;
   logic     prod_valid_ff, prod_valid_in;
   prod_type prod_data_ff, prod_data_in;
   logic     in_adv, prod_adv;
   logic signed [GAIN_WIDTH:0] lin_s, rot_s;

   assign prod_adv  = !prod_valid_ff || prod_ready;
   assign in_adv    = !in_valid_ff || prod_adv;
   assign req_stall = !in_adv;

   assign in_valid_in   = in_adv ? req_valid : in_valid_ff;
   assign prod_valid_in = prod_adv ? in_valid_ff : prod_valid_ff;

   assign lin_s = $signed({1'b0, linear_gain});
   assign rot_s = $signed({1'b0, rotation_gain});

   always_comb begin
      prod_data_in.gx = in_data_ff.forward_speed * lin_s;
      prod_data_in.gy = in_data_ff.side_speed * lin_s;
      prod_data_in.rz = in_data_ff.turn_rate * rot_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         prod_valid_ff <= prod_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_adv && req_valid) begin
         in_data_ff <= req_data;
      end
      if (prod_adv && in_valid_ff) begin
         prod_data_ff <= prod_data_in;
      end
   end

   assign prod_valid = prod_valid_ff;
   assign prod_data  = prod_data_ff;

endmodule

[hw/rtl/mwpm_wheel.sv]
// Wheel mixing and output register stage of the mecanum wheel PWM mixer.
// Forms the four wheel terms, rounds and saturates the duty, and registers the response beat.
// Depends on mwpm_pkg.
module mwpm_wheel
   import mwpm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  prod_valid,
   output logic                  prod_ready,
   input  prod_type              prod_data,
   input  logic [MASK_WIDTH-1:0] invert_mask,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data
);

   localparam int QUOT_WIDTH = TERM_WIDTH - ROUND_SHIFT + 1;

   typedef struct packed {
      logic                  dir;
      logic [DUTY_WIDTH-1:0] on;
      logic [OFF_WIDTH-1:0]  off;
   } wheel_type;

   function automatic wheel_type drive(input logic signed [TERM_WIDTH-1:0] term,
                                       input logic inv);
      logic [TERM_WIDTH-1:0] mag;
      logic [TERM_WIDTH:0]   rnd;
      logic [QUOT_WIDTH-1:0] quot;
      logic [DUTY_WIDTH-1:0] duty;
      wheel_type             w;
      mag  = term[TERM_WIDTH-1] ? $unsigned(-term) : $unsigned(term);
      rnd  = {1'b0, mag} + ((TERM_WIDTH + 1)'(1) << (ROUND_SHIFT - 1));
      quot = rnd[TERM_WIDTH:ROUND_SHIFT];
      duty = (|quot[QUOT_WIDTH-1:DUTY_WIDTH]) ? {DUTY_WIDTH{1'b1}} : quot[DUTY_WIDTH-1:0];
      w.dir = ~term[TERM_WIDTH-1] ^ inv;
      w.on  = ~duty;
      w.off = {1'b1, duty};
      return w;
   endfunction

   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_data_ff, rsp_data_in;
   logic                         out_adv;
   logic signed [TERM_WIDTH-1:0] gx, gy, rz;
   wheel_type                    w1, w2, w3, w4;

   assign out_adv      = !rsp_valid_ff || !rsp_stall;
   assign prod_ready   = out_adv;
   assign rsp_valid_in = out_adv ? prod_valid : rsp_valid_ff;

   assign gx = TERM_WIDTH'(prod_data.gx);
   assign gy = TERM_WIDTH'(prod_data.gy);
   assign rz = TERM_WIDTH'(prod_data.rz);

   always_comb begin
      w1 = drive(gx - gy + rz, invert_mask[0]);
      w2 = drive(gx + gy - rz, invert_mask[1]);
      w3 = drive(gx + gy + rz, invert_mask[2]);
      w4 = drive(gx - gy - rz, invert_mask[3]);
      rsp_data_in.dir_one   = w1.dir;
      rsp_data_in.dir_two   = w2.dir;
      rsp_data_in.dir_three = w3.dir;
      rsp_data_in.dir_four  = w4.dir;
      rsp_data_in.on_one    = w1.on;
      rsp_data_in.on_two    = w2.on;
      rsp_data_in.on_three  = w3.on;
      rsp_data_in.on_four   = w4.on;
      rsp_data_in.off_one   = w1.off;
      rsp_data_in.off_two   = w2.off;
      rsp_data_in.off_three = w3.off;
      rsp_data_in.off_four  = w4.off;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && prod_valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hw/rtl/mecanum_wheel_pwm_mixer_unit.sv]
// Each accepted request beat passes through the input register, the product register and the
// output register in turn. Throughput: one command per cycle while rsp_stall is low, set by
// the three-stage pipeline.
// Reset is synchronous and active high; it empties the pipeline and restores the
// linear gain, rotation gain and invert mask to their defaults.
// Depends on mwpm_pkg, mwpm_product and mwpm_wheel.
module mecanum_wheel_pwm_mixer_unit
   import mwpm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_write,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   logic [GAIN_WIDTH-1:0] linear_gain_ff, linear_gain_in;
   logic [GAIN_WIDTH-1:0] rotation_gain_ff, rotation_gain_in;
   logic [MASK_WIDTH-1:0] invert_mask_ff, invert_mask_in;
   logic                  prod_valid, prod_ready;
   prod_type              prod_data;

   always_comb begin
      linear_gain_in   = linear_gain_ff;
      rotation_gain_in = rotation_gain_ff;
      invert_mask_in   = invert_mask_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_LINEAR_GAIN:   linear_gain_in   = csr_wdata[GAIN_WIDTH-1:0];
            CSR_ROTATION_GAIN: rotation_gain_in = csr_wdata[GAIN_WIDTH-1:0];
            CSR_INVERT_MASK:   invert_mask_in   = csr_wdata[MASK_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         linear_gain_ff   <= LINEAR_GAIN_RESET;
         rotation_gain_ff <= ROTATION_GAIN_RESET;
         invert_mask_ff   <= INVERT_MASK_RESET;
      end else begin
         linear_gain_ff   <= linear_gain_in;
         rotation_gain_ff <= rotation_gain_in;
         invert_mask_ff   <= invert_mask_in;
      end
   end

   mwpm_product u_product (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .linear_gain   (linear_gain_ff),
      .rotation_gain (rotation_gain_ff),
      .prod_valid    (prod_valid),
      .prod_ready    (prod_ready),
      .prod_data     (prod_data)
   );

   mwpm_wheel u_wheel (
      .clock       (clock),
      .reset       (reset),
      .prod_valid  (prod_valid),
      .prod_ready  (prod_ready),
      .prod_data   (prod_data),
      .invert_mask (invert_mask_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

[tb/sv/mwpm_tb_pkg.sv]
// Scoreboard for the mecanum wheel PWM mixer testbench: predicts the four wheel drive
// settings for each command beat and checks every response beat against them.
// Depends on mwpm_pkg.
package mwpm_tb_pkg;
   import mwpm_pkg::*;

   localparam int DUTY_LIMIT = (1 << DUTY_WIDTH) - 1;
   localparam int FIELD_COUNT = 3 * WHEEL_COUNT;
   localparam int REPORT_LIMIT = 10;

   class wheel_drive_scoreboard;
      logic [GAIN_WIDTH-1:0] linear_gain;
      logic [GAIN_WIDTH-1:0] rotation_gain;
      logic [MASK_WIDTH-1:0] invert_mask;
      rsp_type expected_drives[$];
      int unsigned error_count;

      function new();
         linear_gain = LINEAR_GAIN_RESET;
         rotation_gain = ROTATION_GAIN_RESET;
         invert_mask = INVERT_MASK_RESET;
         error_count = 0;
      endfunction

      function void set_register(logic [CSR_ADDR_WIDTH-1:0] index,
                                 logic [CSR_DATA_WIDTH-1:0] value);
         case (index)
            CSR_LINEAR_GAIN: linear_gain = value;
            CSR_ROTATION_GAIN: rotation_gain = value;
            CSR_INVERT_MASK: invert_mask = value[MASK_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function rsp_type mix_wheels(req_type cmd);
         longint gx;
         longint gy;
         longint rz;
         longint mag;
         longint term [WHEEL_COUNT];
         logic [DUTY_WIDTH-1:0] duty;
         logic [WHEEL_COUNT-1:0] dirs;
         logic [DUTY_WIDTH-1:0] on_cnt [WHEEL_COUNT];
         logic [OFF_WIDTH-1:0] off_cnt [WHEEL_COUNT];
         rsp_type drive;
         gx = longint'($signed(cmd.forward_speed)) * longint'(linear_gain);
         gy = longint'($signed(cmd.side_speed)) * longint'(linear_gain);
         rz = longint'($signed(cmd.turn_rate)) * longint'(rotation_gain);
         term[0] = gx - gy + rz;
         term[1] = gx + gy - rz;
         term[2] = gx + gy + rz;
         term[3] = gx - gy - rz;
         for (int k = 0; k < WHEEL_COUNT; k++) begin
            mag = (term[k] < 0) ? -term[k] : term[k];
            mag = (mag + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
            duty = (mag > DUTY_LIMIT) ? DUTY_WIDTH'(DUTY_LIMIT) : DUTY_WIDTH'(mag);
            dirs[k] = (term[k] >= 0) ^ invert_mask[k];
            on_cnt[k] = DUTY_WIDTH'(DUTY_LIMIT) - duty;
            off_cnt[k] = OFF_WIDTH'(DUTY_LIMIT + 1 + int'(duty));
         end
         drive.dir_one = dirs[0];
         drive.dir_two = dirs[1];
         drive.dir_three = dirs[2];
         drive.dir_four = dirs[3];
         drive.on_one = on_cnt[0];
         drive.on_two = on_cnt[1];
         drive.on_three = on_cnt[2];
         drive.on_four = on_cnt[3];
         drive.off_one = off_cnt[0];
         drive.off_two = off_cnt[1];
         drive.off_three = off_cnt[2];
         drive.off_four = off_cnt[3];
         return drive;
      endfunction

      function int unsigned drive_field(rsp_type d, int index);
         case (index)
            0: return d.dir_one;
            1: return d.dir_two;
            2: return d.dir_three;
            3: return d.dir_four;
            4: return d.on_one;
            5: return d.on_two;
            6: return d.on_three;
            7: return d.on_four;
            8: return d.off_one;
            9: return d.off_two;
            10: return d.off_three;
            default: return d.off_four;
         endcase
      endfunction

      function void note_command(req_type cmd);
         expected_drives.push_back(mix_wheels(cmd));
      endfunction

      function void check_drive(rsp_type got);
         string field_names [FIELD_COUNT] = '{"dir_one", "dir_two", "dir_three", "dir_four",
            "on_one", "on_two", "on_three", "on_four",
            "off_one", "off_two", "off_three", "off_four"};
         rsp_type want;
         if (expected_drives.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("response beat with no command pending: %h", got);
            return;
         end
         want = expected_drives.pop_front();
         for (int i = 0; i < FIELD_COUNT; i++) begin
            if (drive_field(want, i) != drive_field(got, i)) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%s mismatch: expected %0d, got %0d", field_names[i],
                           drive_field(want, i), drive_field(got, i));
            end
         end
      endfunction

      function int pending();
         return expected_drives.size();
      endfunction
   endclass

endpackage

[tb/sv/tb_top.sv]
// Top-level testbench for mecanum_wheel_pwm_mixer_unit: drives body velocity commands
// with random gaps and stalls, reprograms the gains between phases and checks every beat.
// Depends on mwpm_pkg and mwpm_tb_pkg.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import mwpm_pkg::*;
   import mwpm_tb_pkg::*;

   localparam int HALF_PERIOD = 5;
   localparam int RESET_CYCLES = 3;
   localparam int QUIET_LIMIT = 1000;
   localparam int SETTLE_CYCLES = 8;
   localparam int SPEED_MAX = (1 << (SPEED_WIDTH - 1)) - 1;
   localparam int SPEED_MIN = -(1 << (SPEED_WIDTH - 1));
   localparam int GAIN_MAX = (1 << GAIN_WIDTH) - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_index = CSR_LINEAR_GAIN;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   int unsigned quiet_cycles = 0;
   int unsigned burst_left = 0;
   wheel_drive_scoreboard drive_book;

   mecanum_wheel_pwm_mixer_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         drive_book.check_drive(rsp_data);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int unsigned idle_gap();
      int unsigned roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   initial begin : sink_stalls
      int unsigned hold;
      int unsigned open_run;
      @(posedge clock);
      forever begin
         hold = idle_gap();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         open_run = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 90)
                                                 : $urandom_range(1, 6);
         repeat (open_run) @(posedge clock);
      end
   end

   function automatic req_type command_of(int x, int y, int z);
      req_type cmd;
      cmd.forward_speed = SPEED_WIDTH'(x);
      cmd.side_speed = SPEED_WIDTH'(y);
      cmd.turn_rate = SPEED_WIDTH'(z);
      return cmd;
   endfunction

   function automatic int edge_speed();
      case ($urandom_range(0, 4))
         0: return SPEED_MIN;
         1: return SPEED_MAX;
         2: return -1;
         3: return 1;
         default: return 0;
      endcase
   endfunction

   function automatic int modest_speed();
      return int'($urandom_range(0, 12000)) - 6000;
   endfunction

   function automatic req_type random_command();
      int unsigned style = $urandom_range(0, 9);
      int shared_speed = modest_speed();
      if (style < 4)
         return command_of(int'($urandom()), int'($urandom()), int'($urandom()));
      if (style < 8)
         return command_of(modest_speed(), modest_speed(), modest_speed());
      if (style == 8)
         return command_of(shared_speed, ($urandom_range(0, 1) == 1) ? shared_speed
                           : -shared_speed, ($urandom_range(0, 1) == 1) ? 0 : modest_speed());
      return command_of(edge_speed(), edge_speed(), edge_speed());
   endfunction

   task automatic send_command(input req_type cmd);
      int unsigned gap;
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else if ($urandom_range(0, 19) == 0) begin
         burst_left = $urandom_range(10, 30);
         gap = 0;
      end else begin
         gap = idle_gap();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= cmd;
      do @(posedge clock); while (req_stall);
      drive_book.note_command(cmd);
   endtask

   task automatic send_random(input int count);
      repeat (count) send_command(random_command());
   endtask

   task automatic drain_drives();
      req_valid <= 1'b0;
      while (drive_book.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_gains(input logic [GAIN_WIDTH-1:0] lin,
                                input logic [GAIN_WIDTH-1:0] rot,
                                input logic [MASK_WIDTH-1:0] mask);
      csr_write <= 1'b1;
      csr_index <= CSR_LINEAR_GAIN;
      csr_wdata <= lin;
      @(posedge clock);
      drive_book.set_register(CSR_LINEAR_GAIN, lin);
      csr_index <= CSR_ROTATION_GAIN;
      csr_wdata <= rot;
      @(posedge clock);
      drive_book.set_register(CSR_ROTATION_GAIN, rot);
      csr_index <= CSR_INVERT_MASK;
      csr_wdata <= CSR_DATA_WIDTH'(mask);
      @(posedge clock);
      drive_book.set_register(CSR_INVERT_MASK, CSR_DATA_WIDTH'(mask));
      csr_write <= 1'b0;
   endtask

   function automatic logic [GAIN_WIDTH-1:0] random_gain();
      if ($urandom_range(0, 1) == 1)
         return GAIN_WIDTH'($urandom_range(0, GAIN_MAX));
      return GAIN_WIDTH'($urandom_range(0, 4096));
   endfunction

   initial begin : stimulus
      drive_book = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Default gains: field extremes, zero terms and tiny commands that round to zero.
      send_command(command_of(0, 0, 0));
      send_command(command_of(SPEED_MAX, 0, 0));
      send_command(command_of(SPEED_MIN, 0, 0));
      send_command(command_of(0, SPEED_MAX, 0));
      send_command(command_of(0, SPEED_MIN, 0));
      send_command(command_of(0, 0, SPEED_MAX));
      send_command(command_of(0, 0, SPEED_MIN));
      send_command(command_of(SPEED_MAX, SPEED_MAX, SPEED_MAX));
      send_command(command_of(SPEED_MIN, SPEED_MIN, SPEED_MIN));
      send_command(command_of(SPEED_MAX, SPEED_MIN, SPEED_MAX));
      send_command(command_of(SPEED_MIN, SPEED_MAX, SPEED_MIN));
      send_command(command_of(4096, 4096, 0));
      send_command(command_of(4096, -4096, 0));
      send_command(command_of(1, 0, 0));
      send_command(command_of(-1, 0, 0));
      send_command(command_of(0, 0, -1));
      send_command(command_of(2048, 1024, -512));
      send_random(100);
      drain_drives();

      // Half-count gains put terms exactly on rounding halves.
      program_gains(GAIN_WIDTH'(128), GAIN_WIDTH'(128), MASK_WIDTH'(0));
      send_command(command_of(4096, 0, 0));
      send_command(command_of(-4096, 0, 0));
      send_command(command_of(12288, 0, 0));
      send_command(command_of(-12288, 0, 0));
      send_command(command_of(0, 0, 4096));
      send_command(command_of(0, 4096, -4096));
      send_random(60);
      drain_drives();

      program_gains('0, '0, '1);
      send_random(40);
      drain_drives();

      program_gains(GAIN_WIDTH'(GAIN_MAX), GAIN_WIDTH'(GAIN_MAX), MASK_WIDTH'(5));
      send_command(command_of(SPEED_MAX, SPEED_MAX, SPEED_MAX));
      send_command(command_of(SPEED_MIN, SPEED_MAX, SPEED_MIN));
      send_command(command_of(1, 0, 0));
      send_command(command_of(0, -1, 1));
      send_random(40);
      drain_drives();

      repeat (4) begin
         program_gains(random_gain(), random_gain(), MASK_WIDTH'($urandom_range(0, 15)));
         send_random(50);
         drain_drives();
      end

      program_gains(LINEAR_GAIN_RESET, ROTATION_GAIN_RESET, INVERT_MASK_RESET);
      send_random(30);
      drain_drives();

      if (drive_book.error_count == 0 && drive_book.pending() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
